/* hdl/wpfc_pkg.sv */
// Shared types and constants of the waypoint PID flow controller.
package wpfc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned RATE_W    = 17;
  localparam int unsigned FLOW_W    = 22;
  localparam int unsigned WIDX_W    = 8;
  localparam int unsigned INTEG_W   = 48;
  localparam int unsigned PROD_W    = GAIN_W + DATA_W;
  localparam int unsigned TERM_W    = 58;
  localparam int unsigned ACC_W     = 60;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 8'd3;

  localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd78643;
  localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd3277;
  localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd6554;
  localparam logic [RATE_W-1:0] RATE_RST   = 17'd1000;

  localparam logic signed [DATA_W-1:0] INT32_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] INT32_MIN   = 32'sh8000_0000;
  localparam logic signed [INTEG_W-1:0] INT48_MAX  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INT48_MIN  = 48'sh8000_0000_0000;
  localparam logic signed [DATA_W-1:0] ADV_LIMIT   = 32'sd3276;
  localparam logic signed [35:0]       FLOW_CLAMP  = 36'sd983040;
  localparam logic signed [35:0]       FLOW_BASE   = 36'sd1966080;

  typedef struct packed {
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] pressure;
    logic [DATA_W-1:0] speed;
  } traj_point_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [RATE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* hdl/wpfc_traj_mem.sv */
// Trajectory memory: one write port and one registered read port.
module wpfc_traj_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  wpfc_pkg::traj_point_t wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output wpfc_pkg::traj_point_t rd_data
);

  wpfc_pkg::traj_point_t mem [DEPTH];
  wpfc_pkg::traj_point_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/wpfc_div.sv */
// Bit-serial restoring divider for the error over the loop rate.
module wpfc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  wpfc_pkg::div_req_t req,
  output wpfc_pkg::div_rsp_t rsp
);

  localparam int unsigned DW    = wpfc_pkg::DATA_W;
  localparam int unsigned RW    = wpfc_pkg::RATE_W;
  localparam int unsigned CNT_W = $clog2(DW);

  typedef enum logic {DV_IDLE, DV_RUN} dv_state_t;

  dv_state_t        state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RW-1:0]    rem_r;
  logic [RW-1:0]    dvs_r;
  logic [DW-1:0]    quo_r;
  logic             done_r;
  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic             fits;

  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        DV_IDLE: begin
          if (req.start) begin
            rem_r   <= '0;
            quo_r   <= req.dividend;
            dvs_r   <= req.divisor;
            cnt_r   <= '0;
            done_r  <= 1'b0;
            state_r <= DV_RUN;
          end
        end
        DV_RUN: begin
          rem_r <= fits ? diff[RW-1:0] : trial[RW-1:0];
          quo_r <= {quo_r[DW-2:0], fits};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DW - 1)) begin
            done_r  <= 1'b1;
            state_r <= DV_IDLE;
          end
        end
      endcase
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* hdl/waypoint_pid_flow_controller.sv */
// Top level of the waypoint PID flow controller.
//
//   channel | handshake                  | payload
//   --------+----------------------------+---------------------------------------------
//   in      | start, busy                | in_req_type, in_point_*, in_measured_x
//   out     | out_valid (one-cycle beat) | out_flow_cmd, out_pressure_cmd, out_speed_cmd,
//           |                            | out_waypoint_index, out_advanced
//   cfg     | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// Clear, append and requests that serve no waypoint leave busy low. A tick that serves a
// waypoint holds busy and its result beat follows in the next cycle; start is accepted only
// while busy is low. The error and its magnitude are formed before the bit-serial
// divider starts, which overlaps the proportional and derivative steps of one shared
// 24 x 32 multiplier; the integral term, saturation and output follow the divider.
// Synchronous active-low reset clears the gains to their defaults and empties the
// trajectory. The receiver cannot stall; each result beat lasts exactly one cycle.
module waypoint_pid_flow_controller #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_req_type,
  input  logic signed [wpfc_pkg::DATA_W-1:0]    in_point_target_x,
  input  logic [wpfc_pkg::DATA_W-1:0]           in_point_pressure,
  input  logic [wpfc_pkg::DATA_W-1:0]           in_point_speed,
  input  logic signed [wpfc_pkg::DATA_W-1:0]    in_measured_x,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wpfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wpfc_pkg::GAIN_W-1:0]           cfg_data,
  output logic                                  out_valid,
  output logic [wpfc_pkg::FLOW_W-1:0]           out_flow_cmd,
  output logic [wpfc_pkg::DATA_W-1:0]           out_pressure_cmd,
  output logic [wpfc_pkg::DATA_W-1:0]           out_speed_cmd,
  output logic [wpfc_pkg::WIDX_W-1:0]           out_waypoint_index,
  output logic                                  out_advanced
);

  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned CW     = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW     = wpfc_pkg::DATA_W;
  localparam int unsigned GW     = wpfc_pkg::GAIN_W;
  localparam int unsigned RW     = wpfc_pkg::RATE_W;
  localparam int unsigned IW     = wpfc_pkg::INTEG_W;
  localparam int unsigned PW     = wpfc_pkg::PROD_W;
  localparam int unsigned TW     = wpfc_pkg::TERM_W;
  localparam int unsigned AC     = wpfc_pkg::ACC_W;
  localparam int unsigned XW     = wpfc_pkg::WIDX_W;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ERR, ST_MAG, ST_PMUL, ST_DMUL, ST_DLO, ST_DHI, ST_DSUM, ST_DACC,
    ST_DIVW, ST_INT, ST_IMAG, ST_ILO, ST_IHI, ST_ISUM, ST_IACC, ST_SAT, ST_OUT
  } state_t;

  state_t                state_r;
  logic [GW-1:0]         gain_p_r;
  logic [GW-1:0]         gain_i_r;
  logic [GW-1:0]         gain_d_r;
  logic [RW-1:0]         rate_r;
  logic [CW-1:0]         point_count_r;
  logic [CW-1:0]         point_index_r;
  logic signed [IW-1:0]  integ_r;
  logic signed [DW-1:0]  prev_r;
  logic signed [DW-1:0]  meas_r;
  logic signed [DW-1:0]  e_r;
  logic [DW-1:0]         emag_r;
  logic                  eneg_r;
  logic signed [DW:0]    dif_r;
  logic [DW-1:0]         dmag_r;
  logic                  dneg_r;
  logic [RW-1:0]         dhi_r;
  logic [PW-17:0]        part_r;
  logic [TW-1:0]         term_r;
  logic signed [AC-1:0]  acc_r;
  logic signed [DW:0]    q_r;
  logic [IW-1:0]         imag_r;
  logic                  ineg_r;
  logic signed [DW-1:0]  u_r;
  logic [PW-1:0]         prod_r;
  logic                  out_valid_r;
  logic [wpfc_pkg::FLOW_W-1:0] out_flow_r;
  logic [DW-1:0]         out_pressure_r;
  logic [DW-1:0]         out_speed_r;
  logic [XW-1:0]         out_widx_r;
  logic                  out_adv_r;

  logic                  accept;
  logic                  full;
  logic                  tick_ok;
  logic [RW-1:0]         rate_eff;
  logic [GW-1:0]         mul_a;
  logic [DW-1:0]         mul_b;
  logic signed [DW:0]    diff33;
  logic signed [DW-1:0]  e_sat;
  logic signed [IW+1:0]  isum;
  logic signed [IW-1:0]  i_sat;
  logic signed [DW-1:0]  u_sat;
  logic signed [35:0]    u36;
  logic signed [35:0]    u10;
  logic signed [35:0]    u_clamp;
  logic signed [35:0]    flow36;
  logic                  adv;
  logic [AC-1:0]         pterm;
  logic [AC-1:0]         term_ext;
  logic [CW+XW-1:0]      idx_wide;

  wpfc_pkg::traj_point_t wr_point;
  wpfc_pkg::traj_point_t rd_point;
  wpfc_pkg::div_req_t    div_req;
  wpfc_pkg::div_rsp_t    div_rsp;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;
  assign full      = (point_count_r == CW'(MAX_POINTS));
  assign tick_ok   = (point_index_r < point_count_r);
  assign rate_eff  = (rate_r == '0) ? RW'(1) : rate_r;

  assign wr_point.target   = in_point_target_x;
  assign wr_point.pressure = in_point_pressure;
  assign wr_point.speed    = in_point_speed;

  wpfc_traj_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept && (in_req_type == wpfc_pkg::REQ_APPEND) && !full),
    .wr_addr (point_count_r[AW-1:0]),
    .wr_data (wr_point),
    .rd_en   (accept && (in_req_type == wpfc_pkg::REQ_TICK)),
    .rd_addr (point_index_r[AW-1:0]),
    .rd_data (rd_point)
  );

  assign div_req.start    = (state_r == ST_PMUL);
  assign div_req.dividend = emag_r;
  assign div_req.divisor  = rate_eff;

  wpfc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_PMUL: begin
        mul_a = gain_p_r;
        mul_b = emag_r;
      end
      ST_DMUL: begin
        mul_a = GW'(rate_eff);
        mul_b = dmag_r;
      end
      ST_DLO: begin
        mul_a = gain_d_r;
        mul_b = prod_r[DW-1:0];
      end
      ST_DHI: begin
        mul_a = gain_d_r;
        mul_b = DW'(dhi_r);
      end
      ST_ILO: begin
        mul_a = gain_i_r;
        mul_b = imag_r[DW-1:0];
      end
      ST_IHI: begin
        mul_a = gain_i_r;
        mul_b = DW'(imag_r[IW-1:DW]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_comb begin
    diff33 = $signed({rd_point.target[DW-1], rd_point.target})
           - $signed({meas_r[DW-1], meas_r});
    if (diff33[DW] != diff33[DW-1]) begin
      e_sat = diff33[DW] ? wpfc_pkg::INT32_MIN : wpfc_pkg::INT32_MAX;
    end else begin
      e_sat = diff33[DW-1:0];
    end

    isum = $signed({{2{integ_r[IW-1]}}, integ_r})
         + $signed({{(IW+1-DW){q_r[DW]}}, q_r});
    if ((&isum[IW+1:IW-1]) || (~|isum[IW+1:IW-1])) begin
      i_sat = isum[IW-1:0];
    end else begin
      i_sat = isum[IW+1] ? wpfc_pkg::INT48_MIN : wpfc_pkg::INT48_MAX;
    end

    if ((&acc_r[AC-1:DW-1]) || (~|acc_r[AC-1:DW-1])) begin
      u_sat = acc_r[DW-1:0];
    end else begin
      u_sat = acc_r[AC-1] ? wpfc_pkg::INT32_MIN : wpfc_pkg::INT32_MAX;
    end

    u36 = $signed({{(36-DW){u_r[DW-1]}}, u_r});
    u10 = (u36 <<< 3) + (u36 <<< 1);
    if (u10 > wpfc_pkg::FLOW_CLAMP) begin
      u_clamp = wpfc_pkg::FLOW_CLAMP;
    end else if (u10 < -wpfc_pkg::FLOW_CLAMP) begin
      u_clamp = -wpfc_pkg::FLOW_CLAMP;
    end else begin
      u_clamp = u10;
    end
    flow36 = wpfc_pkg::FLOW_BASE + u_clamp;
    adv    = (u_r <= wpfc_pkg::ADV_LIMIT) && (u_r >= -wpfc_pkg::ADV_LIMIT);

    pterm    = AC'(prod_r[PW-1:16]);
    term_ext = AC'(term_r);
    idx_wide = {{XW{1'b0}}, point_index_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      gain_p_r      <= wpfc_pkg::GAIN_P_RST;
      gain_i_r      <= wpfc_pkg::GAIN_I_RST;
      gain_d_r      <= wpfc_pkg::GAIN_D_RST;
      rate_r        <= wpfc_pkg::RATE_RST;
      point_count_r <= '0;
      point_index_r <= '0;
      integ_r       <= '0;
      prev_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          wpfc_pkg::CFG_GAIN_P: gain_p_r <= cfg_data;
          wpfc_pkg::CFG_GAIN_I: gain_i_r <= cfg_data;
          wpfc_pkg::CFG_GAIN_D: gain_d_r <= cfg_data;
          wpfc_pkg::CFG_RATE:   rate_r   <= cfg_data[RW-1:0];
          default: begin
          end
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_req_type)
              wpfc_pkg::REQ_CLEAR: begin
                point_count_r <= '0;
                point_index_r <= '0;
                integ_r       <= '0;
                prev_r        <= '0;
              end
              wpfc_pkg::REQ_APPEND: begin
                if (!full) begin
                  point_count_r <= point_count_r + 1'b1;
                end
              end
              wpfc_pkg::REQ_TICK: begin
                meas_r <= in_measured_x;
                if (tick_ok) begin
                  state_r <= ST_ERR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_ERR: begin
          e_r     <= e_sat;
          state_r <= ST_MAG;
        end
        ST_MAG: begin
          eneg_r  <= e_r[DW-1];
          emag_r  <= e_r[DW-1] ? DW'(-e_r) : DW'(e_r);
          dif_r   <= $signed({e_r[DW-1], e_r}) - $signed({prev_r[DW-1], prev_r});
          state_r <= ST_PMUL;
        end
        ST_PMUL: begin
          dneg_r  <= dif_r[DW];
          dmag_r  <= dif_r[DW] ? DW'(-dif_r) : DW'(dif_r);
          state_r <= ST_DMUL;
        end
        ST_DMUL: begin
          acc_r   <= eneg_r ? -$signed(pterm) : $signed(pterm);
          state_r <= ST_DLO;
        end
        ST_DLO: begin
          dhi_r   <= prod_r[DW+RW-1:DW];
          state_r <= ST_DHI;
        end
        ST_DHI: begin
          part_r  <= prod_r[PW-1:16];
          state_r <= ST_DSUM;
        end
        ST_DSUM: begin
          term_r  <= {prod_r[TW-17:0], 16'b0} + TW'(part_r);
          state_r <= ST_DACC;
        end
        ST_DACC: begin
          acc_r   <= dneg_r ? acc_r - $signed(term_ext) : acc_r + $signed(term_ext);
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_rsp.done) begin
            q_r     <= eneg_r ? -$signed({1'b0, div_rsp.quotient})
                              : $signed({1'b0, div_rsp.quotient});
            state_r <= ST_INT;
          end
        end
        ST_INT: begin
          integ_r <= i_sat;
          state_r <= ST_IMAG;
        end
        ST_IMAG: begin
          ineg_r  <= integ_r[IW-1];
          imag_r  <= integ_r[IW-1] ? IW'(-integ_r) : IW'(integ_r);
          state_r <= ST_ILO;
        end
        ST_ILO: begin
          state_r <= ST_IHI;
        end
        ST_IHI: begin
          part_r  <= prod_r[PW-1:16];
          state_r <= ST_ISUM;
        end
        ST_ISUM: begin
          term_r  <= {prod_r[TW-17:0], 16'b0} + TW'(part_r);
          state_r <= ST_IACC;
        end
        ST_IACC: begin
          acc_r   <= ineg_r ? acc_r - $signed(term_ext) : acc_r + $signed(term_ext);
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          u_r     <= u_sat;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          out_valid_r    <= 1'b1;
          out_flow_r     <= flow36[wpfc_pkg::FLOW_W-1:0];
          out_pressure_r <= rd_point.pressure;
          out_speed_r    <= rd_point.speed;
          out_widx_r     <= idx_wide[XW-1:0];
          out_adv_r      <= adv;
          prev_r         <= e_r;
          if (adv) begin
            point_index_r <= point_index_r + 1'b1;
          end
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_flow_cmd       = out_flow_r;
  assign out_pressure_cmd   = out_pressure_r;
  assign out_speed_cmd      = out_speed_r;
  assign out_waypoint_index = out_widx_r;
  assign out_advanced       = out_adv_r;

endmodule
